// ===== design/ssm_pkg.sv =====
// ----------------------------------------------------------------------------
// Scheduled sample mixer package
// Item kinds, status codes and a shared saturation helper function.
// ----------------------------------------------------------------------------
package ssm_pkg;

  localparam logic [1:0] KIND_STORE    = 2'd0;
  localparam logic [1:0] KIND_SCHEDULE = 2'd1;
  localparam logic [1:0] KIND_TICK     = 2'd2;
  localparam logic [1:0] KIND_PULL     = 2'd3;

  localparam logic [2:0] ST_DONE      = 3'd0;
  localparam logic [2:0] ST_STORED    = 3'd1;
  localparam logic [2:0] ST_NO_SLOT   = 3'd2;
  localparam logic [2:0] ST_Q_FULL    = 3'd3;
  localparam logic [2:0] ST_UNDERRUN  = 3'd4;
  localparam logic [2:0] ST_SKIPPED   = 3'd5;

  localparam int unsigned TICK_PERIOD = 16;
  localparam logic [5:0]  REF_MAX     = 6'd63;

  // Saturate a 32-bit signed value to 16 bits.
  function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
    logic signed [15:0] r;
    if (v > 32'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -32'sd32768) begin
      r = -16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

// ===== design/scheduled_sample_mixer.sv =====
// ----------------------------------------------------------------------------
// Scheduled sample mixer
// Clip store, event queue and play ring that schedule and mix short clips.
// ----------------------------------------------------------------------------
// One item at a time. After reset a clearing pass zeroes the clip store, one
// word a cycle, during which no item is accepted. Schedule, pull and skipped
// ticks pass through an execute state and an answer state before their result
// shows. A store adds a clip write state and, when it starts a clip, a slot
// search over up to SLOTS slots. In a working tick the mix buffer is cleared
// one word a cycle, the queue is compacted with a read and a check state per
// entry, each due clip is read and added into the mix buffer one word a cycle
// through its read-modify-write port, and the mix buffer is then copied into
// the play ring with a read and a write state per word. The result is held in
// an output register; the next item is taken in the cycle after it is
// delivered.
module scheduled_sample_mixer #(
  parameter int SLOTS        = 16,
  parameter int SLOT_SAMPLES = 256,
  parameter int RING_DEPTH   = 4096,
  parameter int QUEUE_DEPTH  = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [14:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  // tdata: sample[15:0], time_req[47:16], slot[51:48], zero[55:52]
  input  logic [55:0] in_tdata,
  // tuser: kind[1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // tdata: status[2:0], audio_out[18:3], slot_taken[22:19],
  //        events_mixed[28:23], ring_fill[41:29], zero[47:42]
  output logic [47:0] out_tdata
);

  localparam int SW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int PW  = $clog2(SLOT_SAMPLES);
  localparam int CW  = $clog2(SLOTS * SLOT_SAMPLES);
  localparam int RW  = $clog2(RING_DEPTH);
  localparam int QW  = $clog2(QUEUE_DEPTH);
  localparam int CLIP_WORDS = SLOTS * SLOT_SAMPLES;
  localparam int MW  = 24; // enough for 256 events of 16-bit words

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_OP     = 4'd2;
  localparam logic [3:0] S_SCAN   = 4'd3;
  localparam logic [3:0] S_SCANW  = 4'd4;
  localparam logic [3:0] S_ZERO   = 4'd5;
  localparam logic [3:0] S_QRD    = 4'd6;
  localparam logic [3:0] S_QCHK   = 4'd7;
  localparam logic [3:0] S_ACC    = 4'd8;
  localparam logic [3:0] S_OUTRD  = 4'd9;
  localparam logic [3:0] S_OUTWR  = 4'd10;
  localparam logic [3:0] S_RESP   = 4'd11;

  logic [3:0]  state_r, state_nxt;
  logic [14:0] gain_r;

  // Item registers.
  logic [1:0]  kind_r;
  logic [15:0] smp_r;
  logic [31:0] treq_r;
  logic [SW-1:0] islot_r;

  // Control state.
  logic [5:0]  refcnt_r [SLOTS];
  logic [QW:0] evcnt_r, keep_r, qi_r;
  logic [RW-1:0] rptr_r, wptr_r;
  logic [RW:0] level_r;
  logic [15:0] held_r;
  logic [SW-1:0] sptr_r, scnt_r;
  logic [3:0]  tdiv_r;
  logic [PW:0] spos_r;
  logic        starget_v_r;
  logic [SW-1:0] starget_r;
  logic [CW:0] clr_r;
  logic [PW:0] j_r;
  logic [SW-1:0] mslot_r;
  logic [5:0]  nmix_r;

  // Result registers.
  logic [2:0]  st_r;
  logic [15:0] aud_r;
  logic [SW-1:0] taken_r;
  logic        resp_v_r;

  // Memories.
  logic          clip_we, ring_we, q_we, mix_we;
  logic [CW-1:0] clip_wa, clip_ra;
  logic [15:0]   clip_wd, clip_rd;
  logic [RW-1:0] ring_wa, ring_ra;
  logic [15:0]   ring_wd, ring_rd;
  logic [QW-1:0] q_wa, q_ra;
  logic [35:0]   q_wd, q_rd;
  logic [PW-1:0] mix_wa, mix_ra;
  logic [MW-1:0] mix_wd, mix_rd;

  ssm_ram #(.WIDTH(16), .DEPTH(CLIP_WORDS)) u_clip (
    .clk, .we(clip_we), .waddr(clip_wa), .wdata(clip_wd), .raddr(clip_ra), .rdata(clip_rd));
  ssm_ram #(.WIDTH(16), .DEPTH(RING_DEPTH)) u_ring (
    .clk, .we(ring_we), .waddr(ring_wa), .wdata(ring_wd), .raddr(ring_ra), .rdata(ring_rd));
  ssm_ram #(.WIDTH(36), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk, .we(q_we), .waddr(q_wa), .wdata(q_wd), .raddr(q_ra), .rdata(q_rd));
  ssm_ram #(.WIDTH(MW), .DEPTH(SLOT_SAMPLES)) u_mix (
    .clk, .we(mix_we), .waddr(mix_wa), .wdata(mix_wd), .raddr(mix_ra), .rdata(mix_rd));

  logic in_acc;
  assign in_tready = (state_r == S_IDLE) && !resp_v_r;
  assign in_acc    = in_tvalid && in_tready;
  assign out_tvalid = resp_v_r;
  assign out_tdata = {6'd0, level_r[12:0], nmix_r, 4'(taken_r), aud_r, st_r};

  // Reduce the item's slot modulo SLOTS by repeated subtraction.
  logic [6:0] slot_mod;
  always_comb begin
    slot_mod = {3'd0, in_tdata[51:48]};
    for (int k = 0; k < 8; k++) begin
      if (slot_mod >= 7'(SLOTS)) slot_mod = slot_mod - 7'(SLOTS);
    end
  end

  // Output scaling: gain*2*sample, floor, saturated.
  logic [15:0]        scale_src;
  logic signed [32:0] prod;
  logic signed [15:0] scaled;
  assign scale_src = (level_r != '0) ? ring_rd : held_r;
  assign prod   = $signed({1'b0, gain_r, 1'b0}) * $signed(scale_src);
  assign scaled = ssm_pkg::sat16(32'(prod >>> 15));

  // Addressing and write enables.
  logic [SW-1:0] clip_slot;
  assign clip_slot = starget_v_r ? starget_r : sptr_r;
  logic due;
  assign due = {32'd0, q_rd[31:0]} < {32'd0, treq_r};

  always_comb begin
    clip_we = 1'b0; clip_wa = '0; clip_wd = smp_r;
    clip_ra = CW'({mslot_r, j_r[PW-1:0]});
    ring_we = 1'b0; ring_wa = wptr_r; ring_wd = ssm_pkg::sat16(32'(signed'(mix_rd)));
    ring_ra = rptr_r;
    q_we = 1'b0; q_wa = evcnt_r[QW-1:0];
    q_wd = {4'(islot_r), treq_r};
    q_ra = qi_r[QW-1:0];
    mix_we = 1'b0; mix_wa = j_r[PW-1:0]; mix_wd = '0;
    mix_ra = j_r[PW-1:0];
    case (state_r)
      S_CLEAR: begin
        clip_we = 1'b1; clip_wa = clr_r[CW-1:0]; clip_wd = '0;
      end
      S_OP: begin
        if (kind_r == ssm_pkg::KIND_SCHEDULE && evcnt_r < (QW+1)'(QUEUE_DEPTH)) begin
          q_we = 1'b1;
        end
      end
      S_SCANW: begin
        clip_we = 1'b1;
        clip_wa = CW'({clip_slot, spos_r[PW-1:0]});
      end
      S_ZERO: begin
        mix_we = 1'b1;
      end
      S_QCHK: begin
        if (!due) begin
          q_we = 1'b1; q_wa = keep_r[QW-1:0]; q_wd = q_rd;
        end
      end
      S_ACC: begin
        // j_r leads by one: clip word j_r-1 and mix word j_r-1 are in rdata.
        mix_we = (j_r != '0);
        mix_wa = PW'(j_r - 1'b1);
        mix_wd = MW'(signed'(mix_rd) + signed'(clip_rd));
      end
      S_OUTWR: begin
        ring_we = 1'b1;
      end
      default: ;
    endcase
  end

  // Main sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR; clr_r <= '0; gain_r <= 15'd16384;
      for (int i = 0; i < SLOTS; i++) refcnt_r[i] <= '0;
      evcnt_r <= '0; rptr_r <= '0; wptr_r <= '0; level_r <= '0; held_r <= '0;
      sptr_r <= '0; tdiv_r <= '0; spos_r <= '0; starget_v_r <= 1'b0; starget_r <= '0;
      resp_v_r <= 1'b0;
    end else begin
      if (cfg_we) gain_r <= cfg_wdata;
      if (resp_v_r && out_tready) resp_v_r <= 1'b0;
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == (CW+1)'(CLIP_WORDS - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_acc) begin
            kind_r <= in_tuser; smp_r <= in_tdata[15:0]; treq_r <= in_tdata[47:16];
            islot_r <= SW'(slot_mod);
            st_r <= ssm_pkg::ST_DONE; aud_r <= '0; taken_r <= '0; nmix_r <= '0;
            state_r <= S_OP;
          end
        end
        S_OP: begin
          case (kind_r)
            ssm_pkg::KIND_STORE: begin
              scnt_r <= '0;
              state_r <= starget_v_r ? S_SCANW : S_SCAN;
            end
            ssm_pkg::KIND_SCHEDULE: begin
              state_r <= S_RESP;
              if (evcnt_r >= (QW+1)'(QUEUE_DEPTH)) begin
                st_r <= ssm_pkg::ST_Q_FULL;
              end else begin
                evcnt_r <= evcnt_r + 1'b1;
                if (refcnt_r[islot_r] != ssm_pkg::REF_MAX)
                  refcnt_r[islot_r] <= refcnt_r[islot_r] + 1'b1;
              end
            end
            ssm_pkg::KIND_TICK: begin
              tdiv_r <= tdiv_r + 1'b1;
              if (tdiv_r != 4'(ssm_pkg::TICK_PERIOD - 1)) begin
                st_r <= ssm_pkg::ST_SKIPPED;
                state_r <= S_RESP;
              end else begin
                j_r <= '0; state_r <= S_ZERO;
              end
            end
            default: begin
              state_r <= S_RESP;
              aud_r <= scaled;
              if (level_r != '0) begin
                rptr_r <= rptr_r + 1'b1; level_r <= level_r - 1'b1;
              end else begin
                st_r <= ssm_pkg::ST_UNDERRUN;
              end
            end
          endcase
        end
        // Round-robin search for a slot with zero references, one a cycle.
        S_SCAN: begin
          if (refcnt_r[sptr_r] == '0) begin
            starget_v_r <= 1'b1; starget_r <= sptr_r; spos_r <= '0;
            state_r <= S_SCANW;
          end else if (scnt_r == SW'(SLOTS - 1)) begin
            st_r <= ssm_pkg::ST_NO_SLOT;
            state_r <= S_RESP;
            sptr_r <= (sptr_r == SW'(SLOTS - 1)) ? '0 : sptr_r + 1'b1;
          end else begin
            scnt_r <= scnt_r + 1'b1;
            sptr_r <= (sptr_r == SW'(SLOTS - 1)) ? '0 : sptr_r + 1'b1;
          end
        end
        S_SCANW: begin
          st_r <= ssm_pkg::ST_STORED; taken_r <= clip_slot;
          if (spos_r == (PW+1)'(SLOT_SAMPLES - 1)) begin
            spos_r <= '0; starget_v_r <= 1'b0;
          end else begin
            spos_r <= spos_r + 1'b1;
          end
          state_r <= S_RESP;
        end
        S_ZERO: begin
          j_r <= j_r + 1'b1;
          if (j_r == (PW+1)'(SLOT_SAMPLES - 1)) begin
            qi_r <= '0; keep_r <= '0; state_r <= S_QRD;
          end
        end
        S_QRD: begin
          if (qi_r == evcnt_r) begin
            evcnt_r <= keep_r; j_r <= '0; state_r <= S_OUTRD;
          end else begin
            state_r <= S_QCHK;
          end
        end
        S_QCHK: begin
          qi_r <= qi_r + 1'b1;
          if (due) begin
            mslot_r <= SW'(q_rd[35:32]);
            if (refcnt_r[SW'(q_rd[35:32])] != '0)
              refcnt_r[SW'(q_rd[35:32])] <= refcnt_r[SW'(q_rd[35:32])] - 1'b1;
            nmix_r <= nmix_r + 1'b1;
            j_r <= '0; state_r <= S_ACC;
          end else begin
            keep_r <= keep_r + 1'b1; state_r <= S_QRD;
          end
        end
        S_ACC: begin
          j_r <= j_r + 1'b1;
          if (j_r == (PW+1)'(SLOT_SAMPLES)) state_r <= S_QRD;
        end
        S_OUTRD: begin
          if (j_r == (PW+1)'(SLOT_SAMPLES) || level_r == (RW+1)'(RING_DEPTH))
            state_r <= S_RESP;
          else
            state_r <= S_OUTWR;
        end
        S_OUTWR: begin
          wptr_r <= wptr_r + 1'b1; level_r <= level_r + 1'b1;
          held_r <= ring_wd; j_r <= j_r + 1'b1; state_r <= S_OUTRD;
        end
        S_RESP: begin
          resp_v_r <= 1'b1; state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // No new item while a result is still pending.
  a_no_accept_pending: assert property (@(posedge clk) disable iff (!rst_n)
    resp_v_r |-> !in_tready) else $error("item accepted with result pending");
  // Ring level never exceeds its depth.
  a_level: assert property (@(posedge clk) disable iff (!rst_n)
    level_r <= (RW+1)'(RING_DEPTH)) else $error("ring overfilled");
  // Queue count bounded.
  a_queue: assert property (@(posedge clk) disable iff (!rst_n)
    evcnt_r <= (QW+1)'(QUEUE_DEPTH)) else $error("queue overfilled");
  // A result only follows its response step.
  a_resp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(resp_v_r) |-> $past(state_r) == S_RESP) else $error("stray result");
`endif

endmodule

// ===== design/ssm_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module ssm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== verif/ssm_checker.sv =====
// ----------------------------------------------------------------------------
// Scheduled sample mixer checker
// Watches the input, result and gain channels. It keeps its own clip store,
// event queue and play ring, predicts one result for every accepted item and
// compares each accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module ssm_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [14:0] cfg_wdata,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [55:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [47:0] out_tdata,
  output int          fail_count,
  output int          pending
);

  localparam int SLOTS = 16;
  localparam int SLOT_SAMPLES = 256;
  localparam int RING_DEPTH = 4096;
  localparam int QUEUE_DEPTH = 32;

  // Model state.
  logic [14:0]        gain_q;
  logic signed [15:0] clips [SLOTS*SLOT_SAMPLES];
  logic [5:0]         refcnt [SLOTS];
  logic [31:0]        ev_time [QUEUE_DEPTH];
  logic [3:0]         ev_slot [QUEUE_DEPTH];
  int                 ev_count;
  logic signed [15:0] ring [RING_DEPTH];
  int                 rd_ptr, wr_ptr, level;
  logic signed [15:0] held;
  int                 search_ptr, tick_div, store_pos, store_tgt;

  logic [47:0] expected_results [$];

  assign pending = expected_results.size();

  // Volume scaling: floor(gain*2*s / 2^15), then saturate.
  function automatic logic signed [15:0] scale(input logic signed [15:0] s);
    longint p, q;
    p = longint'(gain_q) * 2 * longint'(s);
    q = p >>> 15;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  // Mix every due event and append the block to the ring.
  function automatic int mix_events(input logic [31:0] now);
    int acc [SLOT_SAMPLES];
    int keep, n, s, w;
    keep = 0;
    n = 0;
    for (int j = 0; j < SLOT_SAMPLES; j++) acc[j] = 0;
    for (int i = 0; i < ev_count; i++) begin
      if (ev_time[i] < now) begin
        s = ev_slot[i];
        for (int j = 0; j < SLOT_SAMPLES; j++) acc[j] += clips[s*SLOT_SAMPLES+j];
        if (refcnt[s] > 0) refcnt[s]--;
        n++;
      end else begin
        ev_time[keep] = ev_time[i];
        ev_slot[keep] = ev_slot[i];
        keep++;
      end
    end
    ev_count = keep;
    for (int j = 0; j < SLOT_SAMPLES && level < RING_DEPTH; j++) begin
      w = acc[j] > 32767 ? 32767 : (acc[j] < -32768 ? -32768 : acc[j]);
      ring[wr_ptr] = w[15:0];
      wr_ptr = (wr_ptr + 1) % RING_DEPTH;
      level++;
      held = w[15:0];
    end
    return n;
  endfunction

  // Predict the result of one item and advance the model.
  function automatic logic [47:0] predict_result(input logic [1:0] kind,
                                                 input logic [55:0] d);
    logic [2:0]         status;
    logic signed [15:0] audio;
    logic [3:0]         taken;
    int                 mixed, p;
    logic               ok;
    status = ssm_pkg::ST_DONE;
    audio = '0;
    taken = '0;
    mixed = 0;
    case (kind)
      ssm_pkg::KIND_STORE: begin
        ok = 1'b1;
        if (store_tgt == 0) begin
          p = search_ptr;
          ok = 1'b0;
          for (int k = 0; k < SLOTS; k++) begin
            if (refcnt[p] == 0) begin
              ok = 1'b1;
              break;
            end
            p = (p + 1) % SLOTS;
          end
          search_ptr = p;
          if (ok) begin
            store_tgt = p + 1;
            store_pos = 0;
          end
        end
        if (ok) begin
          clips[(store_tgt-1)*SLOT_SAMPLES + store_pos] = d[15:0];
          taken = 4'(store_tgt - 1);
          store_pos++;
          if (store_pos >= SLOT_SAMPLES) begin
            store_pos = 0;
            store_tgt = 0;
          end
          status = ssm_pkg::ST_STORED;
        end else begin
          status = ssm_pkg::ST_NO_SLOT;
        end
      end
      ssm_pkg::KIND_SCHEDULE: begin
        if (ev_count >= QUEUE_DEPTH) begin
          status = ssm_pkg::ST_Q_FULL;
        end else begin
          ev_time[ev_count] = d[47:16];
          ev_slot[ev_count] = d[51:48];
          ev_count++;
          if (refcnt[d[51:48]] < ssm_pkg::REF_MAX) refcnt[d[51:48]]++;
        end
      end
      ssm_pkg::KIND_TICK: begin
        tick_div = (tick_div + 1) % ssm_pkg::TICK_PERIOD;
        if (tick_div != 0) status = ssm_pkg::ST_SKIPPED;
        else mixed = mix_events(d[47:16]);
      end
      default: begin
        if (level > 0) begin
          audio = scale(ring[rd_ptr]);
          rd_ptr = (rd_ptr + 1) % RING_DEPTH;
          level--;
        end else begin
          audio = scale(held);
          status = ssm_pkg::ST_UNDERRUN;
        end
      end
    endcase
    return {6'd0, 13'(level), 6'(mixed), taken, audio, status};
  endfunction

  // Track the channels on every rising edge.
  always @(posedge clk) begin
    logic [47:0] exp_r;
    if (!rst_n) begin
      gain_q = 15'd16384;
      for (int i = 0; i < SLOTS*SLOT_SAMPLES; i++) clips[i] = '0;
      for (int i = 0; i < SLOTS; i++) refcnt[i] = '0;
      for (int i = 0; i < RING_DEPTH; i++) ring[i] = '0;
      ev_count = 0;
      rd_ptr = 0;
      wr_ptr = 0;
      level = 0;
      held = '0;
      search_ptr = 0;
      tick_div = 0;
      store_pos = 0;
      store_tgt = 0;
      fail_count = 0;
      expected_results.delete();
    end else begin
      if (cfg_we) gain_q = cfg_wdata;
      if (in_tvalid && in_tready)
        expected_results.push_back(predict_result(in_tuser, in_tdata));
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result %h", out_tdata);
        end else begin
          exp_r = expected_results.pop_front();
          if (exp_r[41:0] !== out_tdata[41:0]) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: status %0d/%0d audio %0d/%0d slot %0d/%0d mixed %0d/%0d fill %0d/%0d",
                       exp_r[2:0], out_tdata[2:0], $signed(exp_r[18:3]),
                       $signed(out_tdata[18:3]), exp_r[22:19], out_tdata[22:19],
                       exp_r[28:23], out_tdata[28:23], exp_r[41:29], out_tdata[41:29]);
          end
        end
      end
    end
  end

endmodule

// ===== verif/tb_scheduled_sample_mixer.sv =====
// ----------------------------------------------------------------------------
// Scheduled sample mixer testbench
// Drives directed and random store, schedule, tick and pull items with bursty
// input and a stalling receiver, changes the gain between phases and reports
// the checker's verdict.
// ----------------------------------------------------------------------------
module tb_scheduled_sample_mixer;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [14:0] cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [55:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  int          fail_count, pending;
  int          burst_left = 0;

  always #10 clk = ~clk;

  scheduled_sample_mixer dut (.*);

  ssm_checker u_checker (.*);

  // Receiver stalls: each cycle ready is drawn anew, and it drops low at random.
  always @(posedge clk) begin
    if (($urandom % 512) < 200) out_tready <= 1'b1;
    else out_tready <= ($urandom % 4) != 0;
  end

  // Send one item, with a random gap before each new burst. The valid stays
  // high after the handshake so that items of a burst follow without a gap.
  task automatic send_item(input logic [1:0] kind, input logic [15:0] smp,
                           input logic [31:0] t, input logic [3:0] slot);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = $urandom_range(0, 6);
    end
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {4'd0, slot, t, smp};
    do @(posedge clk); while (!in_tready);
  endtask

  // Stop sending and wait until every expected result has come.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
  endtask

  // Wait until the block is idle, then write a new gain.
  task automatic set_gain(input logic [14:0] g);
    drain();
    repeat (10) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= g;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Store one full clip of random or constant words.
  task automatic store_clip(input int mode);
    logic [15:0] w;
    for (int i = 0; i < 256; i++) begin
      w = mode == 0 ? 16'($urandom) : (mode == 1 ? 16'h7fff : 16'h8000);
      send_item(ssm_pkg::KIND_STORE, w, 32'($urandom), 4'($urandom));
    end
  endtask

  task automatic ticks(input int n, input logic [31:0] now);
    repeat (n) send_item(ssm_pkg::KIND_TICK, 16'($urandom), now, 4'($urandom));
  endtask

  initial begin
    int k;
    int gains [5] = '{0, 1, 32767, 16384, 12345};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    // Directed: full-scale clips, scheduling, mix and pulls.
    send_item(ssm_pkg::KIND_PULL, 16'd0, 32'd0, 4'd0);
    store_clip(1);
    store_clip(2);
    send_item(ssm_pkg::KIND_SCHEDULE, 16'd0, 32'd0, 4'd0);
    send_item(ssm_pkg::KIND_SCHEDULE, 16'd0, 32'd0, 4'd0);
    send_item(ssm_pkg::KIND_SCHEDULE, 16'd0, 32'hffffffff, 4'd1);
    send_item(ssm_pkg::KIND_SCHEDULE, 16'd0, 32'd5, 4'd15);
    ticks(16, 32'd1);
    repeat (4) send_item(ssm_pkg::KIND_PULL, 16'd0, 32'd0, 4'd0);
    for (int g = 0; g < 5; g++) begin
      set_gain(15'(gains[g]));
      // Random phase mixing clip stores, single stores, schedules, ticks and pulls.
      k = 0;
      while (k < 35) begin
        case ($urandom % 8)
          0: begin
            store_clip($urandom % 3);
            k += 20;
          end
          1, 2: send_item(ssm_pkg::KIND_SCHEDULE, 16'd0, 32'($urandom_range(0, 3000)),
                          4'($urandom));
          3: send_item(ssm_pkg::KIND_SCHEDULE, 16'd0, 32'($urandom), 4'($urandom));
          4: begin
            ticks($urandom_range(1, 16), 32'($urandom_range(0, 4000)));
            k += 4;
          end
          5: send_item(ssm_pkg::KIND_STORE, 16'($urandom), 32'($urandom), 4'($urandom));
          default: begin
            repeat ($urandom_range(1, 40))
              send_item(ssm_pkg::KIND_PULL, 16'($urandom), 32'($urandom), 4'($urandom));
            k += 10;
          end
        endcase
        k++;
      end
      // Fill the queue past its depth to reach the full case.
      if (g == 1) begin
        repeat (40) send_item(ssm_pkg::KIND_SCHEDULE, 16'd0, 32'hfffffff0, 4'($urandom));
        store_clip(0);
        ticks(16, 32'hffffffff);
      end
    end
    drain();
    repeat (1200) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #400000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
